// ===== rtl/ppp_pkg.sv =====
// ppp_pkg: shared widths, register indexes, pipeline payload types and the
// divider step function for the point perspective projector.
// No dependencies.
`default_nettype none

package ppp_pkg;

   // field widths
   localparam int unsigned POINT_W  = 32;
   localparam int unsigned INDEX_W  = 24;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned SCALE_W  = 24;
   localparam int unsigned SCREEN_W = 16;
   localparam int unsigned DEPTH_W  = 19;

   // internal widths
   localparam int unsigned MAG_W    = POINT_W + 1;
   localparam int unsigned NPROD_W  = 2 * POINT_W;
   localparam int unsigned NORM_W   = 19;
   localparam int unsigned TRIG_W   = 16;
   localparam int unsigned TRIG_SH  = 14;
   localparam int unsigned P1_W     = TRIG_W + NORM_W;
   localparam int unsigned ROT_W    = 22;
   localparam int unsigned P2_W     = TRIG_W + ROT_W;
   localparam int unsigned UP_W     = 25;
   localparam int unsigned CD_W     = 26;
   localparam int unsigned DVD_W    = UP_W + SCALE_W;
   localparam int unsigned DVS_W    = DEPTH_W + 4;
   localparam int unsigned QUO_W    = 18;
   localparam int unsigned DIV_BITS = 2;
   localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS;
   localparam int unsigned OFF_W    = QUO_W + 2;
   localparam int unsigned SUM_W    = OFF_W + 1;
   // front stages, divider set-up, divider steps, output
   localparam int unsigned N_STAGES = 9 + DIV_STAGES + 1;

   // constants
   localparam logic signed [NORM_W-1:0] NORM_MAX = 19'sd262143;
   localparam logic signed [NORM_W-1:0] NORM_MIN = -19'sd262144;
   localparam logic signed [CD_W-1:0]   DEPTH_ONE  = 26'sd65536;
   localparam logic signed [CD_W-1:0]   DEPTH_FIVE = 26'sd327680;
   localparam logic signed [CD_W-1:0]   DEPTH_MAX  = 26'sd524287;
   localparam logic [CSR_W-1:0]         TRIG_RESET = 32'h4000_0000;
   localparam logic signed [SUM_W-1:0]  SCREEN_MAX = 21'sd32767;
   localparam logic signed [SUM_W-1:0]  SCREEN_MIN = -21'sd32768;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X   = 3'd0,
      CSR_CENTER_Y   = 3'd1,
      CSR_CENTER_Z   = 3'd2,
      CSR_NORM_GAIN  = 3'd3,
      CSR_YAW_TRIG   = 3'd4,
      CSR_PITCH_TRIG = 3'd5,
      CSR_SCALE      = 3'd6,
      CSR_VIEWPORT   = 3'd7
   } csr_index_type;

   // one divider lane
   typedef struct packed {
      logic [DVD_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
   } div_type;

   // side data travelling alongside the divider
   typedef struct packed {
      logic [DVS_W-1:0]   dvs;
      logic [DEPTH_W-1:0] depth;
      logic [INDEX_W-1:0] idx;
   } carry_type;

   // one restoring division step for quotient bit k
   function automatic div_type div_step(div_type cur, logic [DVS_W-1:0] dvs,
                                        int unsigned k);
      logic [DVD_W-1:0] sh;
      div_type          nxt;
      sh  = DVD_W'(dvs) << k;
      nxt = cur;
      if (cur.rem >= sh) begin
         nxt.rem = cur.rem - sh;
         nxt.quo = cur.quo | (QUO_W'(1) << k);
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ppp_if.sv =====
// ppp channel interfaces: point request, projected response, register write.
// Depends on ppp_pkg for field widths.
`default_nettype none

interface ppp_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ppp_pkg::POINT_W-1:0]  point_x;
   logic signed [ppp_pkg::POINT_W-1:0]  point_y;
   logic signed [ppp_pkg::POINT_W-1:0]  point_z;
   logic        [ppp_pkg::INDEX_W-1:0]  point_id;
   modport source (output valid, point_x, point_y, point_z, point_id, input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_id, output ready);
endinterface

interface ppp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ppp_pkg::SCREEN_W-1:0]  pix_x;
   logic signed [ppp_pkg::SCREEN_W-1:0]  pix_y;
   logic        [ppp_pkg::DEPTH_W-1:0]   view_depth;
   logic        [ppp_pkg::INDEX_W-1:0]   out_index;
   modport source (output valid, pix_x, pix_y, view_depth, out_index,
                   input ready);
   modport sink   (input valid, pix_x, pix_y, view_depth, out_index,
                   output ready);
endinterface

interface ppp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ppp_pkg::CSR_IDX_W-1:0]     index;
   logic [ppp_pkg::CSR_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/point_perspective_projector.sv =====
// point_perspective_projector: centre, normalise, yaw/pitch rotate and
// perspective-project one point per unstalled cycle. Depends on ppp_pkg, ppp_if.
//
//  channel   | dir | carries
//  req_chan  | in  | point_x/y/z (Q16.16), point_id
//  rsp_chan  | out | pix_x/y (Q12.4), view_depth (Q3.16), out_index
//  csr_chan  | in  | register index, 32-bit write data (always ready)
//
// Fully pipelined over 19 register stages: one request enters per cycle
// while the response side does not stall. Nine of the stages belong to the
// restoring divider for scale over depth, two quotient bits per stage.
// Synchronous reset clears the valid bits and loads register defaults.
// A stall at the response side freezes every stage at once; nothing is lost.
`default_nettype none

module point_perspective_projector (
   input  logic           clock,
   input  logic           reset,
   ppp_req_if.sink        req_chan,
   ppp_rsp_if.source      rsp_chan,
   ppp_csr_if.sink        csr_chan
);

   localparam int unsigned NS = ppp_pkg::N_STAGES;
   localparam int unsigned DS = ppp_pkg::DIV_STAGES;

   // configuration registers
   logic signed [ppp_pkg::POINT_W-1:0] cen_ff [3];
   logic [ppp_pkg::CSR_W-1:0]          gain_ff;
   logic [ppp_pkg::CSR_W-1:0]          yaw_ff;
   logic [ppp_pkg::CSR_W-1:0]          pitch_ff;
   logic [ppp_pkg::SCALE_W-1:0]        scale_ff;
   logic [ppp_pkg::CSR_W-1:0]          view_ff;

   // pipeline control
   logic [NS-1:0] vld_ff;
   logic          pipe_adv;
   logic          req_accept;

   // stage payloads
   logic                              s1_neg_ff  [3];
   logic [ppp_pkg::MAG_W-1:0]         s1_mag_ff  [3];
   logic [ppp_pkg::INDEX_W-1:0]       s1_idx_ff;
   logic                              s2_neg_ff  [3];
   logic [ppp_pkg::NPROD_W-1:0]       s2_prod_ff [3];
   logic [ppp_pkg::INDEX_W-1:0]       s2_idx_ff;
   logic signed [ppp_pkg::NORM_W-1:0] s3_n_in    [3];
   logic signed [ppp_pkg::NORM_W-1:0] s3_n_ff    [3];
   logic [ppp_pkg::INDEX_W-1:0]       s3_idx_ff;
   logic signed [ppp_pkg::P1_W-1:0]   s4_cy_nx_ff, s4_sy_ny_ff, s4_sy_nx_ff, s4_cy_ny_ff;
   logic signed [ppp_pkg::NORM_W-1:0] s4_nz_ff;
   logic [ppp_pkg::INDEX_W-1:0]       s4_idx_ff;
   logic signed [ppp_pkg::ROT_W-1:0]  s5_rx_in, s5_ry_in, s5_rx_ff, s5_ry_ff;
   logic signed [ppp_pkg::NORM_W-1:0] s5_nz_ff;
   logic [ppp_pkg::INDEX_W-1:0]       s5_idx_ff;
   logic signed [ppp_pkg::P2_W-1:0]   s6_cp_nz_ff, s6_sp_ry_ff, s6_sp_nz_ff, s6_cp_ry_ff;
   logic signed [ppp_pkg::ROT_W-1:0]  s6_rx_ff;
   logic [ppp_pkg::INDEX_W-1:0]       s6_idx_ff;
   logic signed [ppp_pkg::UP_W-1:0]   s7_up_in, s7_up_ff;
   logic [ppp_pkg::DEPTH_W-1:0]       s7_depth_in, s7_depth_ff;
   logic signed [ppp_pkg::ROT_W-1:0]  s7_rx_ff;
   logic [ppp_pkg::INDEX_W-1:0]       s7_idx_ff;
   logic [ppp_pkg::DVD_W-1:0]         s8_dvd_in [2];
   logic [ppp_pkg::DVD_W-1:0]         s8_dvd_ff [2];
   logic                              s8_neg_ff [2];
   logic [ppp_pkg::DEPTH_W-1:0]       s8_depth_ff;
   logic [ppp_pkg::INDEX_W-1:0]       s8_idx_ff;
   ppp_pkg::div_type                  dv_in [DS+1][2];
   ppp_pkg::div_type                  dv_ff [DS+1][2];
   ppp_pkg::carry_type                dc_in;
   ppp_pkg::carry_type                dc_ff [DS+1];
   logic signed [ppp_pkg::SCREEN_W-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic [ppp_pkg::DEPTH_W-1:0]       depth_ff;
   logic [ppp_pkg::INDEX_W-1:0]       idx_ff;

   // trig terms
   logic signed [ppp_pkg::TRIG_W-1:0] yaw_cos, yaw_sin, pitch_cos, pitch_sin;
   logic signed [ppp_pkg::TRIG_W-1:0] view_x, view_y;
   assign yaw_cos   = yaw_ff[2*ppp_pkg::TRIG_W-1:ppp_pkg::TRIG_W];
   assign yaw_sin   = yaw_ff[ppp_pkg::TRIG_W-1:0];
   assign pitch_cos = pitch_ff[2*ppp_pkg::TRIG_W-1:ppp_pkg::TRIG_W];
   assign pitch_sin = pitch_ff[ppp_pkg::TRIG_W-1:0];
   assign view_x    = view_ff[2*ppp_pkg::SCREEN_W-1:ppp_pkg::SCREEN_W];
   assign view_y    = view_ff[ppp_pkg::SCREEN_W-1:0];

   // handshakes
   assign pipe_adv       = !vld_ff[NS-1] || rsp_chan.ready;
   assign req_chan.ready = pipe_adv;
   assign req_accept     = req_chan.valid && pipe_adv;
   assign csr_chan.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff[0] <= '0;
         cen_ff[1] <= '0;
         cen_ff[2] <= '0;
         gain_ff   <= '0;
         yaw_ff    <= ppp_pkg::TRIG_RESET;
         pitch_ff  <= ppp_pkg::TRIG_RESET;
         scale_ff  <= '0;
         view_ff   <= '0;
      end else if (csr_chan.valid) begin
         case (ppp_pkg::csr_index_type'(csr_chan.index))
            ppp_pkg::CSR_CENTER_X:   cen_ff[0] <= csr_chan.data;
            ppp_pkg::CSR_CENTER_Y:   cen_ff[1] <= csr_chan.data;
            ppp_pkg::CSR_CENTER_Z:   cen_ff[2] <= csr_chan.data;
            ppp_pkg::CSR_NORM_GAIN:  gain_ff   <= csr_chan.data;
            ppp_pkg::CSR_YAW_TRIG:   yaw_ff    <= csr_chan.data;
            ppp_pkg::CSR_PITCH_TRIG: pitch_ff  <= csr_chan.data;
            ppp_pkg::CSR_SCALE:      scale_ff  <= csr_chan.data[ppp_pkg::SCALE_W-1:0];
            ppp_pkg::CSR_VIEWPORT:   view_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_chan.valid};
      end
   end

   // stage 3: round toward minus infinity and clamp to +/-4
   always_comb begin
      logic [ppp_pkg::POINT_W:0]   rq;
      logic [ppp_pkg::NPROD_W:0]   rsum;
      for (int l = 0; l < 3; l++) begin
         rsum = {1'b0, s2_prod_ff[l]} + (ppp_pkg::NPROD_W+1)'(32'hFFFF_FFFF);
         if (s2_neg_ff[l]) begin
            rq = rsum[ppp_pkg::NPROD_W:ppp_pkg::POINT_W];
            if (rq > (ppp_pkg::POINT_W+1)'(262144)) s3_n_in[l] = ppp_pkg::NORM_MIN;
            else s3_n_in[l] = -$signed(rq[ppp_pkg::NORM_W-1:0]);
         end else begin
            rq = {1'b0, s2_prod_ff[l][ppp_pkg::NPROD_W-1:ppp_pkg::POINT_W]};
            if (rq > (ppp_pkg::POINT_W+1)'(262143)) s3_n_in[l] = ppp_pkg::NORM_MAX;
            else s3_n_in[l] = $signed(rq[ppp_pkg::NORM_W-1:0]);
         end
      end
   end

   // stage 5: yaw sums with floor shift
   always_comb begin
      logic signed [ppp_pkg::P1_W:0] ax, ay;
      ax = (ppp_pkg::P1_W+1)'(s4_cy_nx_ff) - (ppp_pkg::P1_W+1)'(s4_sy_ny_ff);
      ay = (ppp_pkg::P1_W+1)'(s4_sy_nx_ff) + (ppp_pkg::P1_W+1)'(s4_cy_ny_ff);
      s5_rx_in = ppp_pkg::ROT_W'(ax >>> ppp_pkg::TRIG_SH);
      s5_ry_in = ppp_pkg::ROT_W'(ay >>> ppp_pkg::TRIG_SH);
   end

   // stage 7: pitch sums and camera depth clamp
   always_comb begin
      logic signed [ppp_pkg::P2_W:0]   au, ad;
      logic signed [ppp_pkg::UP_W-1:0] dd;
      logic signed [ppp_pkg::CD_W-1:0] cd;
      au = (ppp_pkg::P2_W+1)'(s6_cp_nz_ff) - (ppp_pkg::P2_W+1)'(s6_sp_ry_ff);
      ad = (ppp_pkg::P2_W+1)'(s6_sp_nz_ff) + (ppp_pkg::P2_W+1)'(s6_cp_ry_ff);
      s7_up_in = ppp_pkg::UP_W'(au >>> ppp_pkg::TRIG_SH);
      dd       = ppp_pkg::UP_W'(ad >>> ppp_pkg::TRIG_SH);
      cd       = ppp_pkg::DEPTH_FIVE + ppp_pkg::CD_W'(dd);
      if (cd < ppp_pkg::DEPTH_ONE) cd = ppp_pkg::DEPTH_ONE;
      if (cd > ppp_pkg::DEPTH_MAX) cd = ppp_pkg::DEPTH_MAX;
      s7_depth_in = cd[ppp_pkg::DEPTH_W-1:0];
   end

   // stage 8: offset magnitudes times scale
   always_comb begin
      logic [ppp_pkg::UP_W-1:0] mx, my;
      mx = s7_rx_ff[ppp_pkg::ROT_W-1] ? ppp_pkg::UP_W'(-s7_rx_ff) : ppp_pkg::UP_W'(s7_rx_ff);
      my = s7_up_ff[ppp_pkg::UP_W-1] ? ppp_pkg::UP_W'(-s7_up_ff) : ppp_pkg::UP_W'(s7_up_ff);
      s8_dvd_in[0] = ppp_pkg::DVD_W'(mx) * ppp_pkg::DVD_W'(scale_ff);
      s8_dvd_in[1] = ppp_pkg::DVD_W'(my) * ppp_pkg::DVD_W'(scale_ff);
   end

   // divider set-up: saturate when the quotient cannot fit
   always_comb begin
      logic [ppp_pkg::DVS_W-1:0] dvs;
      dvs = {s8_depth_ff, 4'b0000};
      dc_in = '{dvs: dvs, depth: s8_depth_ff, idx: s8_idx_ff};
      for (int l = 0; l < 2; l++) begin
         dv_in[0][l].neg = s8_neg_ff[l];
         if (s8_dvd_ff[l] >= (ppp_pkg::DVD_W'(dvs) << ppp_pkg::QUO_W)) begin
            dv_in[0][l].rem = '0;
            dv_in[0][l].quo = '1;
         end else begin
            dv_in[0][l].rem = s8_dvd_ff[l];
            dv_in[0][l].quo = '0;
         end
      end
   end

   // divider steps, two quotient bits each
   for (genvar j = 1; j <= DS; j++) begin : g_div
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            dv_in[j][l] = ppp_pkg::div_step(
               ppp_pkg::div_step(dv_ff[j-1][l], dc_ff[j-1].dvs,
                                 ppp_pkg::QUO_W - 1 - ppp_pkg::DIV_BITS * (j - 1)),
               dc_ff[j-1].dvs, ppp_pkg::QUO_W - 2 - ppp_pkg::DIV_BITS * (j - 1));
         end
      end
      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            dv_ff[j] <= dv_in[j];
            dc_ff[j] <= dc_ff[j-1];
         end
      end
   end

   // output stage: viewport plus (x) or minus (y) signed offset, saturated
   always_comb begin
      logic signed [ppp_pkg::OFF_W-1:0] ox, oy;
      logic signed [ppp_pkg::SUM_W-1:0] tx, ty;
      ox = dv_ff[DS][0].neg ? -$signed({2'b00, dv_ff[DS][0].quo})
                            :  $signed({2'b00, dv_ff[DS][0].quo});
      oy = dv_ff[DS][1].neg ? -$signed({2'b00, dv_ff[DS][1].quo})
                            :  $signed({2'b00, dv_ff[DS][1].quo});
      tx = ppp_pkg::SUM_W'(view_x) + ppp_pkg::SUM_W'(ox);
      ty = ppp_pkg::SUM_W'(view_y) - ppp_pkg::SUM_W'(oy);
      if (tx > ppp_pkg::SCREEN_MAX) tx = ppp_pkg::SCREEN_MAX;
      if (tx < ppp_pkg::SCREEN_MIN) tx = ppp_pkg::SCREEN_MIN;
      if (ty > ppp_pkg::SCREEN_MAX) ty = ppp_pkg::SCREEN_MAX;
      if (ty < ppp_pkg::SCREEN_MIN) ty = ppp_pkg::SCREEN_MIN;
      sx_in = tx[ppp_pkg::SCREEN_W-1:0];
      sy_in = ty[ppp_pkg::SCREEN_W-1:0];
   end

   // payload registers
   always_ff @(posedge clock) begin
      logic signed [ppp_pkg::MAG_W-1:0] df;
      logic signed [ppp_pkg::POINT_W-1:0] pt [3];
      pt[0] = req_chan.point_x;
      pt[1] = req_chan.point_y;
      pt[2] = req_chan.point_z;
      if (pipe_adv) begin
         // stage 1: centre offset as sign and magnitude
         for (int l = 0; l < 3; l++) begin
            df = ppp_pkg::MAG_W'(pt[l]) - ppp_pkg::MAG_W'(cen_ff[l]);
            s1_neg_ff[l] <= df[ppp_pkg::MAG_W-1];
            s1_mag_ff[l] <= df[ppp_pkg::MAG_W-1] ? ppp_pkg::MAG_W'(-df)
                                                 : ppp_pkg::MAG_W'(df);
         end
         s1_idx_ff <= req_chan.point_id;
         // stage 2: magnitude times gain
         for (int l = 0; l < 3; l++) begin
            s2_neg_ff[l]  <= s1_neg_ff[l];
            s2_prod_ff[l] <= ppp_pkg::NPROD_W'(s1_mag_ff[l][ppp_pkg::POINT_W-1:0])
                             * ppp_pkg::NPROD_W'(gain_ff)
                           + (s1_mag_ff[l][ppp_pkg::POINT_W]
                              ? {gain_ff, 32'h0000_0000} : '0);
         end
         s2_idx_ff <= s1_idx_ff;
         // stage 3
         s3_n_ff   <= s3_n_in;
         s3_idx_ff <= s2_idx_ff;
         // stage 4: yaw products
         s4_cy_nx_ff <= ppp_pkg::P1_W'(yaw_cos) * ppp_pkg::P1_W'(s3_n_ff[0]);
         s4_sy_ny_ff <= ppp_pkg::P1_W'(yaw_sin) * ppp_pkg::P1_W'(s3_n_ff[1]);
         s4_sy_nx_ff <= ppp_pkg::P1_W'(yaw_sin) * ppp_pkg::P1_W'(s3_n_ff[0]);
         s4_cy_ny_ff <= ppp_pkg::P1_W'(yaw_cos) * ppp_pkg::P1_W'(s3_n_ff[1]);
         s4_nz_ff    <= s3_n_ff[2];
         s4_idx_ff   <= s3_idx_ff;
         // stage 5
         s5_rx_ff  <= s5_rx_in;
         s5_ry_ff  <= s5_ry_in;
         s5_nz_ff  <= s4_nz_ff;
         s5_idx_ff <= s4_idx_ff;
         // stage 6: pitch products
         s6_cp_nz_ff <= ppp_pkg::P2_W'(pitch_cos) * ppp_pkg::P2_W'(s5_nz_ff);
         s6_sp_ry_ff <= ppp_pkg::P2_W'(pitch_sin) * ppp_pkg::P2_W'(s5_ry_ff);
         s6_sp_nz_ff <= ppp_pkg::P2_W'(pitch_sin) * ppp_pkg::P2_W'(s5_nz_ff);
         s6_cp_ry_ff <= ppp_pkg::P2_W'(pitch_cos) * ppp_pkg::P2_W'(s5_ry_ff);
         s6_rx_ff    <= s5_rx_ff;
         s6_idx_ff   <= s5_idx_ff;
         // stage 7
         s7_rx_ff    <= s6_rx_ff;
         s7_up_ff    <= s7_up_in;
         s7_depth_ff <= s7_depth_in;
         s7_idx_ff   <= s6_idx_ff;
         // stage 8
         s8_dvd_ff    <= s8_dvd_in;
         s8_neg_ff[0] <= s7_rx_ff[ppp_pkg::ROT_W-1];
         s8_neg_ff[1] <= s7_up_ff[ppp_pkg::UP_W-1];
         s8_depth_ff  <= s7_depth_ff;
         s8_idx_ff    <= s7_idx_ff;
         // stage 9: divider entry
         dv_ff[0] <= dv_in[0];
         dc_ff[0] <= dc_in;
         // output register
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         depth_ff <= dc_ff[DS].depth;
         idx_ff   <= dc_ff[DS].idx;
      end
   end

   // response port
   assign rsp_chan.valid      = vld_ff[NS-1];
   assign rsp_chan.pix_x      = sx_ff;
   assign rsp_chan.pix_y      = sy_ff;
   assign rsp_chan.view_depth = depth_ff;
   assign rsp_chan.out_index  = idx_ff;

   // checks
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.view_depth >= ppp_pkg::DEPTH_W'(65536))
      else $error("camera depth below one");

endmodule

`default_nettype wire
